/* rtl/lpfr_pkg.sv */
// Shared types and constants for the length-prefixed frame receiver.
// No dependencies; used by lpfr_core and length_prefixed_frame_receiver.
package lpfr_pkg;

    localparam int unsigned LENGTH_FIELD_BITS_DEF = 16;
    localparam int unsigned MAX_LENGTH_RESET      = 1024;
    localparam int unsigned MIN_LENGTH            = 4;
    localparam int unsigned BYTE_BITS             = 8;
    localparam int unsigned INDEX_BITS            = 17;
    localparam int unsigned CFG_INDEX_BITS        = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_HEADER_BYTE = 2'd0,
        CFG_MAX_LENGTH  = 2'd1
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_GOOD    = 3'd1,
        ST_BAD_SUM = 3'd2,
        ST_SHORT   = 3'd3,
        ST_LONG    = 3'd4
    } t_status;

    typedef struct packed {
        logic                  emit;
        logic [BYTE_BITS-1:0]  value;
        logic [INDEX_BITS-1:0] index;
        logic                  last;
        t_status               status;
    } t_result;

endpackage

/* rtl/lpfr_core.sv */
// Frame tracking state and per-byte decision logic.
// Depends on lpfr_pkg; instantiated by length_prefixed_frame_receiver.
module lpfr_core #(
    parameter int unsigned LENGTH_FIELD_BITS = lpfr_pkg::LENGTH_FIELD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_take,
    input  logic [lpfr_pkg::BYTE_BITS-1:0]    i_rx_byte,
    input  logic [lpfr_pkg::BYTE_BITS-1:0]    i_header_byte,
    input  logic [lpfr_pkg::INDEX_BITS-1:0]   i_max_length,
    output lpfr_pkg::t_result                 o_result
);

    logic                              r_in_frame,     n_in_frame;
    logic [lpfr_pkg::INDEX_BITS-1:0]   r_position,     n_position;
    logic [lpfr_pkg::INDEX_BITS-1:0]   r_bytes_left,   n_bytes_left;
    logic [lpfr_pkg::BYTE_BITS-1:0]    r_length_high,  n_length_high;
    logic [LENGTH_FIELD_BITS-1:0]      r_frame_length, n_frame_length;
    logic [lpfr_pkg::BYTE_BITS-1:0]    r_running_sum,  n_running_sum;

    logic [2*lpfr_pkg::BYTE_BITS-1:0]  len_raw;
    logic [LENGTH_FIELD_BITS-1:0]      len;
    logic [lpfr_pkg::INDEX_BITS-1:0]   len_plus1;
    logic [lpfr_pkg::INDEX_BITS-1:0]   left_dec;

    assign len_raw   = {r_length_high, i_rx_byte};
    assign len       = len_raw[LENGTH_FIELD_BITS-1:0];
    assign len_plus1 = lpfr_pkg::INDEX_BITS'(len) + lpfr_pkg::INDEX_BITS'(1);
    assign left_dec  = (r_bytes_left == '0) ? '0
                     : r_bytes_left - lpfr_pkg::INDEX_BITS'(1);

    always_comb begin
        n_in_frame     = r_in_frame;
        n_position     = r_position;
        n_bytes_left   = r_bytes_left;
        n_length_high  = r_length_high;
        n_frame_length = r_frame_length;
        n_running_sum  = r_running_sum;
        o_result.emit   = 1'b1;
        o_result.value  = i_rx_byte;
        o_result.index  = r_position;
        o_result.last   = 1'b0;
        o_result.status = lpfr_pkg::ST_BUSY;

        if (!r_in_frame) begin
            o_result.index = '0;
            if (i_rx_byte == i_header_byte) begin
                n_in_frame    = 1'b1;
                n_running_sum = '0;
                n_bytes_left  = '0;
                n_position    = lpfr_pkg::INDEX_BITS'(1);
            end else begin
                o_result.emit = 1'b0;
            end
        end else if (r_position == lpfr_pkg::INDEX_BITS'(1)) begin
            n_length_high = i_rx_byte;
            n_position    = lpfr_pkg::INDEX_BITS'(2);
        end else if (r_position == lpfr_pkg::INDEX_BITS'(2)) begin
            n_frame_length = len;
            if (len_plus1 > i_max_length) begin
                n_in_frame      = 1'b0;
                n_position      = '0;
                n_bytes_left    = '0;
                o_result.last   = 1'b1;
                o_result.status = lpfr_pkg::ST_LONG;
            end else begin
                n_bytes_left = len_plus1;
                n_position   = lpfr_pkg::INDEX_BITS'(3);
            end
        end else begin
            n_bytes_left = left_dec;
            if (left_dec == '0) begin
                n_in_frame    = 1'b0;
                n_position    = '0;
                o_result.last = 1'b1;
                if (r_frame_length < LENGTH_FIELD_BITS'(lpfr_pkg::MIN_LENGTH)) begin
                    o_result.status = lpfr_pkg::ST_SHORT;
                end else if (i_rx_byte == r_running_sum) begin
                    o_result.status = lpfr_pkg::ST_GOOD;
                end else begin
                    o_result.status = lpfr_pkg::ST_BAD_SUM;
                end
            end else begin
                n_running_sum = r_running_sum + i_rx_byte;
                n_position    = r_position + lpfr_pkg::INDEX_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame     <= 1'b0;
            r_position     <= '0;
            r_bytes_left   <= '0;
            r_length_high  <= '0;
            r_frame_length <= '0;
            r_running_sum  <= '0;
        end else if (i_take) begin
            r_in_frame     <= n_in_frame;
            r_position     <= n_position;
            r_bytes_left   <= n_bytes_left;
            r_length_high  <= n_length_high;
            r_frame_length <= n_frame_length;
            r_running_sum  <= n_running_sum;
        end
    end

endmodule

/* rtl/length_prefixed_frame_receiver.sv */
// Length-prefixed frame receiver: top level with configuration and result register.
// Depends on lpfr_pkg and lpfr_core.
//
// Takes one received byte per cycle unless the input is stalled, and returns at
// most one result per byte, held in a result register. A frame opens on the
// configured header byte, carries a big-endian length L in bytes 1 and 2, then L
// summed bytes and an 8-bit additive checksum. Each in-frame byte is echoed with its
// index; the closing or aborting byte has last set and a final status. The input
// is stalled only while the result register is full and its transfer is stalled.
// Configuration writes are always ready and must be issued while idle.
module length_prefixed_frame_receiver #(
    parameter int unsigned LENGTH_FIELD_BITS = lpfr_pkg::LENGTH_FIELD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [lpfr_pkg::BYTE_BITS-1:0]      i_rx_byte,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [lpfr_pkg::BYTE_BITS-1:0]      o_byte_value,
    output logic [lpfr_pkg::INDEX_BITS-1:0]     o_byte_index,
    output logic                                o_last,
    output logic [2:0]                          o_status,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lpfr_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [lpfr_pkg::INDEX_BITS-1:0]     i_cfg_data
);

    logic [lpfr_pkg::BYTE_BITS-1:0]  r_header_byte;
    logic [lpfr_pkg::INDEX_BITS-1:0] r_max_length;
    logic                            r_valid;
    lpfr_pkg::t_result               r_result;
    lpfr_pkg::t_result               result;
    logic                            take;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_valid & i_stall;
    assign take        = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte <= '0;
            r_max_length  <= lpfr_pkg::INDEX_BITS'(lpfr_pkg::MAX_LENGTH_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lpfr_pkg::CFG_HEADER_BYTE: r_header_byte <= i_cfg_data[lpfr_pkg::BYTE_BITS-1:0];
                lpfr_pkg::CFG_MAX_LENGTH:  r_max_length  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lpfr_core #(
        .LENGTH_FIELD_BITS (LENGTH_FIELD_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_rx_byte     (i_rx_byte),
        .i_header_byte (r_header_byte),
        .i_max_length  (r_max_length),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= result.emit;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= result;
        end
    end

    assign o_valid      = r_valid;
    assign o_byte_value = r_result.value;
    assign o_byte_index = r_result.index;
    assign o_last       = r_result.last;
    assign o_status     = r_result.status;

endmodule

/* sim/tb_length_prefixed_frame_receiver.sv */
// Self-checking testbench for length_prefixed_frame_receiver: directed and random frames,
// randomised idling on both channels, per-byte echo checking against a behavioural model.
// Depends on rtl/lpfr_pkg.sv and rtl/length_prefixed_frame_receiver.sv.
`timescale 1ns / 100ps

module tb_length_prefixed_frame_receiver;

    localparam int unsigned  STALL_LIMIT = 4000;
    localparam int unsigned  ITEMS_PER_PHASE = 300;
    localparam logic [15:0]  LEN_MASK =
        16'((32'd1 << lpfr_pkg::LENGTH_FIELD_BITS_DEF) - 1);

    typedef struct {
        logic [lpfr_pkg::BYTE_BITS-1:0]  value;
        logic [lpfr_pkg::INDEX_BITS-1:0] index;
        logic                            last;
        lpfr_pkg::t_status               status;
    } t_frame_echo;

    class t_frame_echo_board;
        t_frame_echo           due_echoes[$];
        int unsigned           mismatches;
        logic [7:0]            hdr_byte;
        logic [16:0]           max_len;
        logic                  in_frame;
        logic [16:0]           position;
        logic [16:0]           bytes_left;
        logic [7:0]            length_high;
        logic [15:0]           frame_length;
        logic [7:0]            running_sum;

        function new();
            mismatches   = 0;
            hdr_byte     = 8'd0;
            max_len      = 17'(lpfr_pkg::MAX_LENGTH_RESET);
            in_frame     = 1'b0;
            position     = '0;
            bytes_left   = '0;
            length_high  = '0;
            frame_length = '0;
            running_sum  = '0;
        endfunction

        function void set_reg(lpfr_pkg::t_cfg_index idx, logic [16:0] data);
            if (idx == lpfr_pkg::CFG_HEADER_BYTE) begin
                hdr_byte = data[7:0];
            end else if (idx == lpfr_pkg::CFG_MAX_LENGTH) begin
                max_len = data;
            end
        endfunction

        // Advance the frame state by one received byte and queue the echo it causes.
        function void take_byte(logic [7:0] b);
            t_frame_echo e;
            logic [15:0] len;
            e.value  = b;
            e.index  = position;
            e.last   = 1'b0;
            e.status = lpfr_pkg::ST_BUSY;
            if (!in_frame) begin
                if (b != hdr_byte) return;
                in_frame    = 1'b1;
                running_sum = '0;
                bytes_left  = '0;
                position    = 17'd1;
                e.index     = '0;
            end else if (position == 17'd1) begin
                length_high = b;
                position    = 17'd2;
            end else if (position == 17'd2) begin
                len          = {length_high, b} & LEN_MASK;
                frame_length = len;
                if (int'(len) + 1 > int'(max_len)) begin
                    in_frame   = 1'b0;
                    position   = '0;
                    bytes_left = '0;
                    e.last     = 1'b1;
                    e.status   = lpfr_pkg::ST_LONG;
                end else begin
                    bytes_left = 17'(len) + 17'd1;
                    position   = 17'd3;
                end
            end else begin
                if (bytes_left != 0) bytes_left = bytes_left - 17'd1;
                if (bytes_left == 0) begin
                    e.last = 1'b1;
                    if (frame_length < lpfr_pkg::MIN_LENGTH) begin
                        e.status = lpfr_pkg::ST_SHORT;
                    end else if (b == running_sum) begin
                        e.status = lpfr_pkg::ST_GOOD;
                    end else begin
                        e.status = lpfr_pkg::ST_BAD_SUM;
                    end
                    in_frame = 1'b0;
                    position = '0;
                end else begin
                    running_sum = running_sum + b;
                    position    = position + 17'd1;
                end
            end
            due_echoes.push_back(e);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_echo(logic [7:0] v, logic [16:0] idx, logic l, logic [2:0] st);
            t_frame_echo e;
            if (due_echoes.size() == 0) begin
                $display("%0t: unexpected echo: expected none, actual value %0d index %0d",
                         $time, v, idx);
                mismatches++;
                return;
            end
            e = due_echoes.pop_front();
            compare_field("byte_value", 32'(e.value), 32'(v));
            compare_field("byte_index", 32'(e.index), 32'(idx));
            compare_field("last", 32'(e.last), 32'(l));
            compare_field("status", 32'(e.status), 32'(st));
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    logic [lpfr_pkg::BYTE_BITS-1:0]      i_rx_byte;
    logic                                o_valid;
    logic                                i_stall;
    logic [lpfr_pkg::BYTE_BITS-1:0]      o_byte_value;
    logic [lpfr_pkg::INDEX_BITS-1:0]     o_byte_index;
    logic                                o_last;
    logic [2:0]                          o_status;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [lpfr_pkg::CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [lpfr_pkg::INDEX_BITS-1:0]     i_cfg_data;

    t_frame_echo_board sb;
    logic              calm;
    int unsigned       frame_bytes_sent;
    int unsigned       quiet_cycles;

    length_prefixed_frame_receiver dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_byte_value (o_byte_value),
        .o_byte_index (o_byte_index),
        .o_last       (o_last),
        .o_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(negedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < 20);
    end

    // Check the echo before noting the new byte: its own echo is registered and checked later.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sb.check_echo(o_byte_value, o_byte_index, o_last, o_status);
            end
            if (i_valid && !o_stall) begin
                sb.take_byte(i_rx_byte);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_length_prefixed_frame_receiver: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic pause_input(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // Drain outstanding echoes, then allow for the result register latency.
    task automatic settle();
        pause_input(1);
        while (sb.due_echoes.size() != 0) pause_input(1);
        pause_input(4);
    endtask

    task automatic write_reg(input lpfr_pkg::t_cfg_index idx, input logic [16:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input logic [15:0] len, input bit good_sum);
        logic [7:0] hdr;
        logic [7:0] sum;
        logic [7:0] b;
        hdr = sb.hdr_byte;
        sum = '0;
        send_byte(hdr);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        frame_bytes_sent += 3;
        if (int'(len & LEN_MASK) + 1 > int'(sb.max_len)) return;
        for (int i = 0; i < int'(len & LEN_MASK); i++) begin
            b = (i == 1 || $urandom_range(7) == 0) ? hdr : 8'($urandom);
            sum = sum + b;
            send_byte(b);
        end
        send_byte(good_sum ? sum : sum + 8'($urandom_range(1, 255)));
        frame_bytes_sent += int'(len & LEN_MASK) + 1;
    endtask

    function automatic logic [15:0] pick_length(logic [16:0] lim);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) return 16'($urandom_range(0, 3));
        if (r < 30 && lim <= 64 && lim != 0) return 16'(lim - $urandom_range(0, 1));
        return 16'($urandom_range(4, 24));
    endfunction

    initial begin
        logic [16:0] phase_limit [6];
        logic [15:0] len;
        logic [7:0]  junk;
        int unsigned r;
        phase_limit = '{17'd1, 17'd5, 17'd12, 17'd65536, 17'd40, 17'd300};
        sb               = new();
        calm             = 1'b0;
        frame_bytes_sent = 0;
        quiet_cycles     = 0;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_rx_byte        = '0;
        i_stall          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = lpfr_pkg::CFG_HEADER_BYTE;
        i_cfg_data       = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: header 0x00, limit 1024.
        send_byte(8'h55);
        send_byte(8'hFF);
        send_frame(16'd4, 1'b1);
        send_frame(16'd5, 1'b0);
        send_frame(16'd0, 1'b1);
        send_frame(16'd2, 1'b0);
        send_frame(16'd1024, 1'b1);
        settle();
        write_reg(lpfr_pkg::CFG_HEADER_BYTE, 17'h000A5);
        write_reg(lpfr_pkg::CFG_MAX_LENGTH, 17'd0);
        send_frame(16'd0, 1'b1);
        settle();
        write_reg(lpfr_pkg::CFG_MAX_LENGTH, 17'd1);
        send_frame(16'd0, 1'b0);
        send_frame(16'd1, 1'b1);
        send_frame(16'hFFFF, 1'b1);

        for (int p = 0; p < 6; p++) begin
            settle();
            write_reg(lpfr_pkg::CFG_HEADER_BYTE,
                      (p == 0) ? 17'h000FF : 17'($urandom_range(0, 255)));
            write_reg(lpfr_pkg::CFG_MAX_LENGTH, phase_limit[p]);
            calm = (p == 3);
            while (frame_bytes_sent < (p + 1) * ITEMS_PER_PHASE) begin
                r = $urandom_range(99);
                if (r < 70) begin
                    send_frame(pick_length(sb.max_len), $urandom_range(99) < 80);
                end else if (r < 80) begin
                    repeat ($urandom_range(1, 6)) begin
                        do junk = 8'($urandom); while (junk == sb.hdr_byte);
                        send_byte(junk);
                    end
                end else begin
                    len[15:8] = (sb.max_len <= 1024) ? 8'($urandom) : 8'($urandom_range(0, 1));
                    len[7:0]  = 8'($urandom);
                    send_frame(len, 1'($urandom_range(1)));
                end
            end
        end
        calm = 1'b0;

        settle();
        pause_input(8);
        if (sb.mismatches == 0 && sb.due_echoes.size() == 0) begin
            $display("tb_length_prefixed_frame_receiver: PASS");
        end else begin
            $display("tb_length_prefixed_frame_receiver: FAIL");
        end
        $finish;
    end

endmodule
